// ===== hdl/mh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Magnetometer heading package
// Shared widths, constants, the stage record and the arctangent table.
// ----------------------------------------------------------------------------
package mh_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned AtanLen     = 24;
  localparam int unsigned CordicIters = (CordicSteps > AtanLen) ? AtanLen : CordicSteps;

  localparam int unsigned VecW  = 27;
  localparam int unsigned AngW  = 32;
  localparam int unsigned ProdW = 48;
  localparam int unsigned HeadW = 16;
  localparam int unsigned DiffW = 18;

  localparam logic [HeadW-1:0]        FullTurn   = 16'd46080;
  localparam logic signed [HeadW-1:0] DeclReset  = 16'sd335;
  localparam logic [AngW-1:0]         QuarterPos = 32'h4000_0000;
  localparam logic [AngW-1:0]         QuarterNeg = 32'hC000_0000;
  localparam logic [ProdW-1:0]        RoundHalf  = 48'h0000_8000_0000;

  typedef struct packed {
    logic                   zero;
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic [AngW-1:0]        z;
  } vec_t;

  function automatic logic [AngW-1:0] atan_lookup(input logic [4:0] idx);
    logic [AngW-1:0] val;
    case (idx)
      5'd0:    val = 32'd536870912;
      5'd1:    val = 32'd316933406;
      5'd2:    val = 32'd167458907;
      5'd3:    val = 32'd85004756;
      5'd4:    val = 32'd42667331;
      5'd5:    val = 32'd21354465;
      5'd6:    val = 32'd10680862;
      5'd7:    val = 32'd5340245;
      5'd8:    val = 32'd2670163;
      5'd9:    val = 32'd1335087;
      5'd10:   val = 32'd667544;
      5'd11:   val = 32'd333772;
      5'd12:   val = 32'd166886;
      5'd13:   val = 32'd83443;
      5'd14:   val = 32'd41721;
      5'd15:   val = 32'd20860;
      5'd16:   val = 32'd10430;
      5'd17:   val = 32'd5215;
      5'd18:   val = 32'd2607;
      5'd19:   val = 32'd1303;
      5'd20:   val = 32'd651;
      5'd21:   val = 32'd325;
      5'd22:   val = 32'd162;
      5'd23:   val = 32'd81;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/mh_prerotate.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Magnetometer heading input stage
// Folds the vector into the right half plane and scales it for the CORDIC.
// ----------------------------------------------------------------------------
module mh_prerotate (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire logic               valid_i,
  input  wire logic signed [15:0] x_i,
  input  wire logic signed [15:0] y_i,
  output mh_pkg::vec_t            vec_o,
  output logic                    valid_o
);

  logic signed [16:0]         xe, ye, xr, yr;
  logic signed [mh_pkg::VecW-1:0] xw, yw;
  mh_pkg::vec_t               vec_d, vec_q;
  logic                       valid_q;

  always_comb begin
    xe = {x_i[15], x_i};
    ye = {y_i[15], y_i};
    vec_d.zero = (xe == 17'sd0) && (ye == 17'sd0);
    if (xe[16]) begin
      if (!ye[16]) begin
        xr = ye;
        yr = -xe;
        vec_d.z = mh_pkg::QuarterPos;
      end else begin
        xr = -ye;
        yr = xe;
        vec_d.z = mh_pkg::QuarterNeg;
      end
    end else begin
      xr = xe;
      yr = ye;
      vec_d.z = '0;
    end
    xw = mh_pkg::VecW'(xr);
    yw = mh_pkg::VecW'(yr);
    vec_d.x = xw <<< 8;
    vec_d.y = yw <<< 8;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      vec_q <= vec_d;
    end
  end

  assign vec_o   = vec_q;
  assign valid_o = valid_q;

endmodule
`default_nettype wire

// ===== hdl/mh_cordic.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Magnetometer heading CORDIC pipeline
// Vectoring CORDIC with one registered micro-rotation per stage.
// ----------------------------------------------------------------------------
module mh_cordic (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         adv_i,
  input  wire logic         valid_i,
  input  wire mh_pkg::vec_t vec_i,
  output mh_pkg::vec_t      vec_o,
  output logic              valid_o
);

  logic         vld [mh_pkg::CordicIters+1];
  mh_pkg::vec_t stg [mh_pkg::CordicIters+1];

  assign vld[0] = valid_i;
  assign stg[0] = vec_i;

  for (genvar i = 0; i < mh_pkg::CordicIters; i++) begin : g_step
    logic signed [mh_pkg::VecW-1:0] xs, ys;
    mh_pkg::vec_t                   nxt;

    always_comb begin
      xs = stg[i].x >>> i;
      ys = stg[i].y >>> i;
      nxt.zero = stg[i].zero;
      if (!stg[i].y[mh_pkg::VecW-1]) begin
        nxt.x = stg[i].x + ys;
        nxt.y = stg[i].y - xs;
        nxt.z = stg[i].z + mh_pkg::atan_lookup(5'(i));
      end else begin
        nxt.x = stg[i].x - ys;
        nxt.y = stg[i].y + xs;
        nxt.z = stg[i].z - mh_pkg::atan_lookup(5'(i));
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[i+1] <= 1'b0;
      end else if (adv_i) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i && vld[i]) begin
        stg[i+1] <= nxt;
      end
    end
  end

  assign vec_o   = stg[mh_pkg::CordicIters];
  assign valid_o = vld[mh_pkg::CordicIters];

endmodule
`default_nettype wire

// ===== hdl/mh_scale.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Magnetometer heading output scaling
// Converts the binary angle to 1/128 degree, applies declination and wraps.
// ----------------------------------------------------------------------------
module mh_scale (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       adv_i,
  input  wire logic                       valid_i,
  input  wire logic [mh_pkg::AngW-1:0]    angle_i,
  input  wire logic signed [15:0]         decl_i,
  output logic [mh_pkg::HeadW-1:0]        heading_o,
  output logic                            valid_o
);

  logic [mh_pkg::ProdW-1:0]        prod_q, sum;
  logic [mh_pkg::HeadW-1:0]        raw;
  logic signed [mh_pkg::DiffW-1:0] diff_d, diff_q, turn;
  logic [mh_pkg::HeadW-1:0]        heading_d, heading_q;
  logic                            va_q, vb_q, vc_q;

  always_comb begin
    sum = prod_q + mh_pkg::RoundHalf;
    raw = sum[mh_pkg::ProdW-1:mh_pkg::ProdW-mh_pkg::HeadW];
    if (raw == mh_pkg::FullTurn) begin
      raw = '0;
    end
    diff_d = $signed({2'b00, raw}) - mh_pkg::DiffW'(decl_i);
  end

  always_comb begin
    turn = $signed({2'b00, mh_pkg::FullTurn});
    if (diff_q[mh_pkg::DiffW-1]) begin
      heading_d = mh_pkg::HeadW'(diff_q + turn);
    end else if (diff_q >= turn) begin
      heading_d = mh_pkg::HeadW'(diff_q - turn);
    end else begin
      heading_d = mh_pkg::HeadW'(diff_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (adv_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      prod_q <= mh_pkg::ProdW'(angle_i) * mh_pkg::ProdW'(mh_pkg::FullTurn);
    end
    if (adv_i && va_q) begin
      diff_q <= diff_d;
    end
    if (adv_i && vb_q) begin
      heading_q <= heading_d;
    end
  end

  assign heading_o = heading_q;
  assign valid_o   = vc_q;

endmodule
`default_nettype wire

// ===== hdl/magnetometer_heading.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Magnetometer heading
// Compass heading in 1/128 degree from one X/Y magnetometer sample.
// ----------------------------------------------------------------------------
// The block accepts one sample request per clock while the output is not
// stalled and returns one heading per sample, in order, through one input
// fold stage, one stage per CORDIC micro-rotation, then a multiply stage, a
// declination stage and the output register. A stall on the output freezes
// the whole pipeline, so the input stalls in the same cycle. The declination
// register should be written only while no request is in flight.
module magnetometer_heading (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] x_count_i,
  input  wire logic signed [15:0] y_count_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [15:0]             heading_o,
  input  wire logic               cfg_we_i,
  input  wire logic signed [15:0] cfg_data_i
);

  logic                      adv;
  logic signed [15:0]        decl_q;
  mh_pkg::vec_t              pre_vec, cor_vec;
  logic                      pre_valid, cor_valid;
  logic [mh_pkg::AngW-1:0]   angle;

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decl_q <= mh_pkg::DeclReset;
    end else if (cfg_we_i) begin
      decl_q <= cfg_data_i;
    end
  end

  mh_prerotate u_pre (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .x_i     (x_count_i),
    .y_i     (y_count_i),
    .vec_o   (pre_vec),
    .valid_o (pre_valid)
  );

  mh_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (pre_valid),
    .vec_i   (pre_vec),
    .vec_o   (cor_vec),
    .valid_o (cor_valid)
  );

  assign angle = cor_vec.zero ? '0 : cor_vec.z;

  mh_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .valid_i   (cor_valid),
    .angle_i   (angle),
    .decl_i    (decl_q),
    .heading_o (heading_o),
    .valid_o   (out_valid_o)
  );

  a_heading_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (heading_o < mh_pkg::FullTurn))
    else $error("Heading is outside one full turn.");

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> pre_valid)
    else $error("Accepted request did not enter the pipeline.");

  a_zero_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (x_count_i == 16'sd0) && (y_count_i == 16'sd0))
      |=> pre_vec.zero)
    else $error("Zero vector was not flagged.");

endmodule
`default_nettype wire
